### hdl/http_chunked_body_tracker_core_defines.svh
// assertion macros used by the checker file
`ifndef HTTP_CHUNKED_BODY_TRACKER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_TRACKER_CORE_DEFINES_SVH

// checked only while out of reset
`define CHBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CHBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/chbt_pkg.sv
// shared types, phase codes and character codes for the chunked body tracker
package chbt_pkg;

  localparam logic [1:0] PH_SIZE    = 2'd0;
  localparam logic [1:0] PH_SIZE_LF = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;
  localparam logic [1:0] PH_LAST_LF = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
  } byte_class_t;

  typedef struct packed {
    logic message_done;
    logic in_chunk_data;
    logic size_overflow;
  } result_t;

endpackage

### hdl/chbt_byte_class.sv
// classifies one byte as hex digit, CR or LF
module chbt_byte_class
  import chbt_pkg::*;
(
  input  logic [7:0]  data_byte,
  output byte_class_t cls
);

  always_comb begin
    cls.is_hex = 1'b0;
    cls.digit  = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      cls.is_hex = 1'b1;
      cls.digit  = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share low bits 1..6
      cls.is_hex = 1'b1;
      cls.digit  = data_byte[3:0] + 4'd9;
    end
    cls.is_cr = (data_byte == CHAR_CR);
    cls.is_lf = (data_byte == CHAR_LF);
  end

endmodule

### hdl/chbt_frame_step.sv
// next phase, count and overflow flag for one byte
module chbt_frame_step
  import chbt_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic [1:0]            phase,
  input  logic [COUNT_BITS-1:0] count,
  input  logic                  ovf,
  input  byte_class_t           cls,
  output logic [1:0]            phase_nxt,
  output logic [COUNT_BITS-1:0] count_nxt,
  output logic                  ovf_nxt,
  output result_t               res
);

  logic [COUNT_BITS-1:0] digit_ext;
  logic [COUNT_BITS-1:0] count_dec;
  logic                  shift_ovf;
  logic                  crlf_ovf;

  assign digit_ext = {{(COUNT_BITS-4){1'b0}}, cls.digit};
  assign count_dec = count - {{(COUNT_BITS-1){1'b0}}, 1'b1};
  // count*16+digit fits only while the top nibble is clear
  assign shift_ovf = |count[COUNT_BITS-1 -: 4];
  // count+2 overflows for the two largest values
  assign crlf_ovf  = &count[COUNT_BITS-1:1];

  always_comb begin
    phase_nxt = phase;
    count_nxt = count;
    ovf_nxt   = ovf;
    res.message_done  = 1'b0;
    res.in_chunk_data = 1'b0;
    unique case (phase)
      PH_SIZE: begin
        if (cls.is_hex) begin
          if (shift_ovf) begin
            count_nxt = '1;
            ovf_nxt   = 1'b1;
          end else begin
            count_nxt = {count[COUNT_BITS-5:0], 4'b0000} | digit_ext;
          end
        end else if (cls.is_cr) begin
          phase_nxt = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (cls.is_lf) begin
          phase_nxt = PH_BODY;
          if (count != '0) begin
            if (crlf_ovf) begin
              count_nxt = '1;
              ovf_nxt   = 1'b1;
            end else begin
              count_nxt = count + {{(COUNT_BITS-2){1'b0}}, 2'd2};
            end
          end
        end
      end
      PH_BODY: begin
        if (count != '0) begin
          res.in_chunk_data = 1'b1;
          count_nxt = count_dec;
          if (count_dec == '0) begin
            // last byte of the chunk also starts the next size line
            phase_nxt = PH_SIZE;
            if (cls.is_hex) begin
              count_nxt = digit_ext;
            end else if (cls.is_cr) begin
              phase_nxt = PH_SIZE_LF;
            end
          end
        end else if (cls.is_cr) begin
          phase_nxt = PH_LAST_LF;
        end
      end
      PH_LAST_LF: begin
        if (cls.is_lf) begin
          res.message_done = 1'b1;
          phase_nxt = PH_SIZE;
        end
      end
      default: begin
        phase_nxt = PH_SIZE;
      end
    endcase
    res.size_overflow = ovf_nxt;
  end

endmodule

### hdl/http_chunked_body_tracker_core.sv
// top level of the chunked body framing tracker
//
//  channel | dir | payload ports                                        | handshake
//  in      | in  | in_data_byte                                         | in_valid / in_stall
//  out     | out | out_message_done out_in_chunk_data out_size_overflow | out_valid / out_stall
//
// one byte per cycle sustained while the result is not stalled; a byte passes through the
// input register, then the phase/count update into the result register
// the count update is one compare and add on COUNT_BITS bits
// synchronous active-low reset clears phase, count, overflow flag and valids
// a stalled result freezes the result stage and a full input register; in_stall rises
// only when the input register is full and cannot move on
module http_chunked_body_tracker_core
  import chbt_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_message_done,
  output logic       out_in_chunk_data,
  output logic       out_size_overflow
);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  out_valid_r;
  result_t               res_r;
  logic [1:0]            phase_r;
  logic [1:0]            phase_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  ovf_r;
  logic                  ovf_nxt;
  result_t               res_nxt;
  byte_class_t           cls;
  logic                  advance;
  logic                  process;
  logic                  s1_load;

  assign advance  = !out_valid_r || !out_stall;
  assign process  = s1_valid_r && advance;
  // an empty input register takes a byte even while the result is stalled
  assign s1_load  = advance || !s1_valid_r;
  assign in_stall = !s1_load;

  chbt_byte_class u_class (
    .data_byte (s1_byte_r),
    .cls       (cls)
  );

  chbt_frame_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .phase     (phase_r),
    .count     (count_r),
    .ovf       (ovf_r),
    .cls       (cls),
    .phase_nxt (phase_nxt),
    .count_nxt (count_nxt),
    .ovf_nxt   (ovf_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SIZE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (process) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_byte_r <= in_data_byte;
    end
    if (process) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_message_done  = res_r.message_done;
  assign out_in_chunk_data = res_r.in_chunk_data;
  assign out_size_overflow = res_r.size_overflow;

endmodule

### hdl/chbt_checker.sv
// port-level checks for the chunked body tracker, bound to the top level
`include "http_chunked_body_tracker_core_defines.svh"

module chbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_message_done,
  input logic       out_in_chunk_data,
  input logic       out_size_overflow
);

  logic out_xact;
  assign out_xact = out_valid && !out_stall;

  // a byte cannot be both chunk data and the final LF
  `CHBT_ASSERT(a_done_excl_data, out_valid |-> !(out_message_done && out_in_chunk_data), "done with chunk data")

  // overflow stays set for every later result
  `CHBT_ASSERT(a_ovf_sticky, (out_valid && out_size_overflow) |=> (!out_valid || out_size_overflow), "overflow flag dropped")

  // a completed message needs a full CR LF CR LF sequence before the next one
  `CHBT_ASSERT(a_done_not_twice, (out_xact && out_message_done) |=> !(out_valid && out_message_done), "done on consecutive results")

  // a stalled result holds
  `CHBT_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable({out_message_done, out_in_chunk_data, out_size_overflow})), "stalled result changed")

  // nothing comes out right after reset
  `CHBT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind http_chunked_body_tracker_core chbt_checker u_chbt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_message_done  (out_message_done),
  .out_in_chunk_data (out_in_chunk_data),
  .out_size_overflow (out_size_overflow)
);

### test/tb_http_chunked_body_tracker_core.sv
// testbench for the chunked body tracker: directed and random byte streams checked per result
`timescale 1ns / 1ps

module tb_http_chunked_body_tracker_core;
  import chbt_pkg::*;

  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LO_A  = "a";
  localparam logic [7:0] CH_LO_F  = "f";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_F  = "F";
  localparam logic [7:0] CH_FILL  = "-";
  localparam logic [7:0] CH_SEMI  = ";";

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_message_done;
  logic       out_in_chunk_data;
  logic       out_size_overflow;

  http_chunked_body_tracker_core #(
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_message_done (out_message_done),
    .out_in_chunk_data(out_in_chunk_data),
    .out_size_overflow(out_size_overflow)
  );

  // predicted framing state, advanced once per accepted byte
  logic [1:0]       pr_phase;
  logic [CNT_W-1:0] pr_count;
  logic             pr_ovf;

  result_t pending_flags[$];
  int      errors;
  int      items_sent;
  int      cycles;
  int      send_idle_pct;
  int      recv_stall_pct;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("http_chunked_body_tracker_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int hex_value(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
    if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic void size_char(input logic [7:0] b);
    int d;
    d = hex_value(b);
    if (d >= 0) begin
      if (pr_count > ((CNT_MAX - CNT_W'(d)) >> 4)) begin
        pr_count = CNT_MAX;
        pr_ovf = 1'b1;
      end else begin
        pr_count = (pr_count << 4) + CNT_W'(d);
      end
    end else if (b == CHAR_CR) begin
      pr_phase = PH_SIZE_LF;
    end
  endfunction

  function automatic result_t track_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (pr_phase)
      PH_SIZE: size_char(b);
      PH_SIZE_LF: begin
        if (b == CHAR_LF) begin
          // room for the crlf after the payload
          if (pr_count != 0) begin
            if (pr_count > CNT_MAX - 2) begin
              pr_count = CNT_MAX;
              pr_ovf = 1'b1;
            end else begin
              pr_count = pr_count + 2;
            end
          end
          pr_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (pr_count != 0) begin
          r.in_chunk_data = 1'b1;
          pr_count = pr_count - 1;
          // the last counted byte is also seen as a size line byte
          if (pr_count == 0) begin
            pr_phase = PH_SIZE;
            size_char(b);
          end
        end else if (b == CHAR_CR) begin
          pr_phase = PH_LAST_LF;
        end
      end
      default: begin
        if (b == CHAR_LF) begin
          r.message_done = 1'b1;
          pr_phase = PH_SIZE;
        end
      end
    endcase
    r.size_overflow = pr_ovf;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: unexpected transaction, got done=%0b data=%0b ovf=%0b", $time,
                 out_message_done, out_in_chunk_data, out_size_overflow);
        errors++;
      end else begin
        want = pending_flags.pop_front();
        if (out_message_done !== want.message_done) begin
          $display("%0t: message_done expected %0b got %0b", $time, want.message_done,
                   out_message_done);
          errors++;
        end
        if (out_in_chunk_data !== want.in_chunk_data) begin
          $display("%0t: in_chunk_data expected %0b got %0b", $time, want.in_chunk_data,
                   out_in_chunk_data);
          errors++;
        end
        if (out_size_overflow !== want.size_overflow) begin
          $display("%0t: size_overflow expected %0b got %0b", $time, want.size_overflow,
                   out_size_overflow);
          errors++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_flags.push_back(track_byte(b));
    items_sent++;
  endtask

  // random byte that cannot push a size count out of the small range
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (pr_phase == PH_SIZE && hex_value(b) >= 0 && pr_count >= 'h10) b = CH_FILL;
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + 8'(d);
    if ($urandom_range(1)) return CH_UP_A + 8'(d - 10);
    return CH_LO_A + 8'(d - 10);
  endfunction

  function automatic logic [7:0] ext_char();
    logic [7:0] pick[6];
    pick = '{";", "=", " ", "k", "x", "z"};
    return pick[$urandom_range(5)];
  endfunction

  task automatic send_size_line(input int sz);
    int zeros;
    int n;
    zeros = $urandom_range(0, 2);
    repeat (zeros) send_byte(CH_ZERO);
    if (sz >= 16) send_byte(digit_char(sz >> 4));
    send_byte(digit_char(sz & 15));
    if ($urandom_range(3) == 0) begin
      send_byte(CH_SEMI);
      n = $urandom_range(1, 3);
      repeat (n) send_byte(ext_char());
    end
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_message();
    int n_chunks;
    int sz;
    n_chunks = $urandom_range(0, 3);
    repeat (n_chunks) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(16, 63) : $urandom_range(1, 8);
      send_size_line(sz);
      repeat (sz) send_byte(8'($urandom_range(255)));
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
    send_size_line(0);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // drive the framing back to an empty size line
  task automatic return_to_idle();
    while (!(pr_phase == PH_SIZE && pr_count == 0)) begin
      case (pr_phase)
        PH_SIZE:    send_byte(CHAR_CR);
        PH_SIZE_LF: send_byte(CHAR_LF);
        PH_BODY: begin
          if (pr_count != 0) send_byte(CH_FILL);
          else send_byte(CHAR_CR);
        end
        default:    send_byte(CHAR_LF);
      endcase
    end
  endtask

  task automatic test_directed_framing();
    logic [7:0] seq[25];
    seq = '{8'h00, "z", "0", "2", CHAR_CR, "q", CHAR_LF,
            "A", 8'hff, CHAR_CR, "3",
            CHAR_CR, CHAR_LF, "e", 8'h80, CHAR_LF, CHAR_CR, CHAR_LF,
            "0", CHAR_CR, CHAR_LF, "x", CHAR_CR, "y", CHAR_LF};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (seq[i]) send_byte(seq[i]);
    return_to_idle();
  endtask

  task automatic run_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int target;
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(4) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(noise_byte());
        return_to_idle();
      end else begin
        send_message();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(0, 0, 90);
    run_traffic(86, 0, 90);
    run_traffic(0, 86, 90);
    run_traffic(15, 15, 90);
  endtask

  // must run last: a saturated count cannot be worked off and the flag is sticky
  task automatic test_size_overflow();
    return_to_idle();
    repeat (7) send_byte(CH_UP_F);
    send_byte(CH_LO_F);
    send_byte(CH_UP_A);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    repeat (4) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= 8'h00;
    out_stall      <= 1'b0;
    errors         = 0;
    items_sent     = 0;
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pr_phase       = PH_SIZE;
    pr_count       = '0;
    pr_ovf         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_framing();
    test_random_traffic();
    test_size_overflow();

    in_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("http_chunked_body_tracker_core: match");
    end else begin
      $display("http_chunked_body_tracker_core: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/chbt_pkg.sv
hdl/chbt_byte_class.sv
hdl/chbt_frame_step.sv
hdl/http_chunked_body_tracker_core.sv
hdl/chbt_checker.sv
test/tb_http_chunked_body_tracker_core.sv
